/* rtl/core/esd_pkg.sv */
// ============================================================================
// esd_pkg: shared types for the escape sequence decoder
// Word formats of the input and result channels and the decode-to-queue bundle.
// ============================================================================
`default_nettype none

package esd_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [31:0] char_value;
        logic        from_escape;
        logic        last_of_run;
    } out_word_t;

    // Up to two result words caused by one input word.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } dec_result_t;

endpackage

`default_nettype wire

/* rtl/core/esd_decode.sv */
// ============================================================================
// esd_decode: escape decode state machine
// Holds the mode, accumulator and octal digit count; decodes one word per fire.
// ============================================================================
`default_nettype none

module esd_decode #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire esd_pkg::in_word_t    item,
    output esd_pkg::dec_result_t      res
);
    import esd_pkg::*;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [1:0] OCT_LAST       = 2'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_BACKSLASH,
        MODE_OCTAL,
        MODE_HEX
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [1:0]             oct_cnt_reg, oct_cnt_next;

    logic [VALUE_WIDTH-1:0] esc_val;
    logic [VALUE_WIDTH-1:0] oct_shift;
    logic [VALUE_WIDTH-1:0] hex_shift;
    logic                   emit_esc;
    logic                   emit_plain;
    logic                   do_plain;
    logic                   is_oct;
    logic                   is_hex;
    logic [3:0]             hex_val;
    logic [7:0]             b;
    out_word_t              esc_word;
    out_word_t              plain_word;

    // Named escapes; anything else stands for itself.
    function automatic logic [7:0] named_map(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        unique case (c)
            8'h61:   v = 8'd7;    // a
            8'h62:   v = 8'd8;    // b
            8'h66:   v = 8'd12;   // f
            8'h6e:   v = 8'd10;   // n
            8'h72:   v = 8'd13;   // r
            8'h73:   v = CHAR_SPACE; // s
            8'h74:   v = 8'd9;    // t
            8'h76:   v = 8'd11;   // v
            8'h45:   v = 8'd27;   // E
            default: v = c;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] to_char(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign b      = item.byte_in;
    assign is_oct = (b[7:3] == 5'b00110);

    always_comb
    begin
        is_hex  = 1'b0;
        hex_val = b[3:0];
        if (b >= 8'h30 && b <= 8'h39)
        begin
            is_hex = 1'b1;
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            is_hex  = 1'b1;
            hex_val = b[3:0] + 4'd9;
        end
    end

    assign oct_shift = (acc_reg << 3) | VALUE_WIDTH'(b[2:0]);
    assign hex_shift = (acc_reg << 4) | VALUE_WIDTH'(hex_val);

    always_comb
    begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        oct_cnt_next = oct_cnt_reg;
        emit_esc     = 1'b0;
        esc_val      = acc_reg;
        do_plain     = 1'b0;
        emit_plain   = 1'b0;

        if (item.end_of_string)
        begin
            // Flush any pending escape, then back to normal.
            if (mode_reg == MODE_BACKSLASH)
            begin
                emit_esc = 1'b1;
                esc_val  = '0;
            end
            else if (mode_reg == MODE_OCTAL || mode_reg == MODE_HEX)
            begin
                emit_esc = 1'b1;
            end
            mode_next    = MODE_NORMAL;
            acc_next     = '0;
            oct_cnt_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    do_plain = 1'b1;
                end
                MODE_BACKSLASH:
                begin
                    if (is_oct)
                    begin
                        acc_next     = VALUE_WIDTH'(b[2:0]);
                        oct_cnt_next = 2'd1;
                        mode_next    = MODE_OCTAL;
                    end
                    else if (b == CHAR_X)
                    begin
                        acc_next  = '0;
                        mode_next = MODE_HEX;
                    end
                    else
                    begin
                        emit_esc  = 1'b1;
                        esc_val   = VALUE_WIDTH'(named_map(b));
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_OCTAL:
                begin
                    if (is_oct)
                    begin
                        if (oct_cnt_reg == OCT_LAST)
                        begin
                            emit_esc     = 1'b1;
                            esc_val      = oct_shift;
                            mode_next    = MODE_NORMAL;
                            acc_next     = '0;
                            oct_cnt_next = '0;
                        end
                        else
                        begin
                            acc_next     = oct_shift;
                            oct_cnt_next = oct_cnt_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        emit_esc     = 1'b1;
                        acc_next     = '0;
                        oct_cnt_next = '0;
                        do_plain     = 1'b1;
                    end
                end
                MODE_HEX:
                begin
                    if (is_hex)
                    begin
                        acc_next = hex_shift;
                    end
                    else
                    begin
                        emit_esc = 1'b1;
                        acc_next = '0;
                        do_plain = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            // Terminator byte or plain byte: backslash opens a new escape.
            if (do_plain)
            begin
                if (b == CHAR_BACKSLASH)
                begin
                    mode_next = MODE_BACKSLASH;
                end
                else
                begin
                    mode_next  = MODE_NORMAL;
                    emit_plain = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        esc_word.char_value    = to_char(esc_val);
        esc_word.from_escape   = 1'b1;
        esc_word.last_of_run   = !emit_plain;
        plain_word.char_value  = 32'(b);
        plain_word.from_escape = 1'b0;
        plain_word.last_of_run = 1'b1;

        res.count  = 2'(emit_esc) + 2'(emit_plain);
        res.first  = emit_esc ? esc_word : plain_word;
        res.second = plain_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            acc_reg     <= '0;
            oct_cnt_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            oct_cnt_reg <= oct_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/esd_out_queue.sv */
// ============================================================================
// esd_out_queue: result word queue
// Four-entry queue taking up to two words per cycle, draining one per cycle while result_ready is high.
// ============================================================================
`default_nettype none

module esd_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire esd_pkg::dec_result_t res,
    output logic                      room,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output esd_pkg::out_word_t        result
);
    import esd_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    out_word_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      push_n;
    logic            pop;

    assign push_n       = push ? res.count : 2'd0;
    assign pop          = result_valid && result_ready;
    assign result_valid = (cnt_reg != '0);
    assign result       = mem_reg[rd_ptr_reg];
    assign room         = (cnt_reg <= CW'(DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign cnt_next    = cnt_reg + CW'(push_n) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= res.first;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("push without room for two words");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == AW'(rd_ptr_reg + cnt_reg[AW-1:0]))
        else $error("queue pointers disagree with count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (cnt_reg >= $past(cnt_reg)))
        else $error("stalled word dropped");

endmodule

`default_nettype wire

/* rtl/core/escape_sequence_decoder_top.sv */
// ============================================================================
// escape_sequence_decoder_top: streaming backslash escape decoder
// Byte stream in, decoded character words out, up to two per input word.
// ============================================================================
// Usage:
//   Input channel item_valid/item_ready/item carries one byte per word, or an
//   end-of-string marker that flushes a pending escape (no byte carried).
//   Output channel result_valid/result_ready/result carries decoded values;
//   last_of_run marks the final word caused by one input word.
//   A word accepted into the input register is decoded and written to the
//   result queue once the queue has room; the queue then offers it.
//   Throughput: one input word per cycle while results are drained; an input
//   word that ends an octal or hex escape on a plain byte gives two results,
//   and the single output port then sets the rate to one result per cycle.
//   The input register feeds the decode logic, which fires when the
//   four-entry result queue has space for two words.
//   A stalled receiver fills the queue; input is then held off, nothing lost.
//   Reset (rst_n low, asynchronous) empties the input register and queue and
//   returns the decoder to normal mode with a cleared accumulator.
// ============================================================================
`default_nettype none

module escape_sequence_decoder_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire esd_pkg::in_word_t  item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output esd_pkg::out_word_t      result
);
    import esd_pkg::*;

    // Input register stage.
    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        room;
    logic        fire;
    dec_result_t res;

    // Decode fires only when the queue can take both possible results.
    assign fire       = in_valid_reg && room;
    assign item_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_word_reg <= item;
        end
    end

    esd_decode #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_word_reg),
        .res   (res)
    );

    esd_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fire),
        .res          (res),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

/* tb/tb_escape_sequence_decoder_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_escape_sequence_decoder_top: self-checking bench for the escape decoder
// Drives byte and end-of-string words into the decoder and keeps a
// cycle-free model of the decode rules. Every result word is checked against
// the model. Directed cases run first: plain bytes, named escapes, octal and
// hex escapes, flushes, and a deliberate receiver stall. Then a long random
// stream of mostly well-formed escapes runs, with random idling on both
// channels.
// ============================================================================

module tb_escape_sequence_decoder_top;
    import esd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_GAP       = 14;
    localparam int LONG_HOLD     = 80;   // receiver stall, well past queue depth
    localparam int FLOOD_REPEATS = 10;   // 3 words each, two results per repeat
    localparam int SETTLE_CYCLES = 6;    // input reg + decode + queue, with slack
    localparam int STALL_LIMIT   = 1000; // cycles without any handshake
    localparam int RANDOM_WORDS  = 350;
    localparam int MAX_REPORTS   = 10;

    // Characters that steer the decode
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = "0";
    localparam logic [7:0] CH_SEVEN     = "7";
    localparam logic [7:0] CH_NINE      = "9";
    localparam logic [7:0] CH_LOWER_A   = "a";
    localparam logic [7:0] CH_LOWER_F   = "f";
    localparam logic [7:0] CH_UPPER_A   = "A";
    localparam logic [7:0] CH_UPPER_F   = "F";
    localparam logic [7:0] CH_HEX_START = "x";
    localparam int         HEX_LETTER_BASE = 10;

    // Values of the named escapes
    localparam logic [31:0] VAL_BELL      = 32'd7;
    localparam logic [31:0] VAL_BACKSPACE = 32'd8;
    localparam logic [31:0] VAL_FORMFEED  = 32'd12;
    localparam logic [31:0] VAL_NEWLINE   = 32'd10;
    localparam logic [31:0] VAL_RETURN    = 32'd13;
    localparam logic [31:0] VAL_SPACE     = 32'd32;
    localparam logic [31:0] VAL_TAB       = 32'd9;
    localparam logic [31:0] VAL_VTAB      = 32'd11;
    localparam logic [31:0] VAL_ESCAPE    = 32'd27;

    typedef enum logic [1:0] {
        DM_PLAIN,
        DM_AFTER_BSLASH,
        DM_OCTAL,
        DM_HEX
    } decode_mode_e;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_word_t  item;
    logic      result_valid;
    logic      result_ready;
    out_word_t result;

    escape_sequence_decoder_top #(
        .VALUE_WIDTH (32)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // Decode model state and the queue of characters still owed by the DUT
    // ------------------------------------------------------------------------
    decode_mode_e model_mode;
    logic [31:0]  model_acc;
    logic [1:0]   model_octal_cnt;
    out_word_t    run_chars[$];       // results of the word being modeled
    out_word_t    expected_chars[$];

    // Run statistics
    int words_sent      = 0;
    int end_words       = 0;
    int chars_checked   = 0;
    int escape_chars    = 0;
    int two_result_runs = 0;
    int mismatches      = 0;
    int stall_cycles    = 0;

    // Idling controls shared by sender, receiver and the tests
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;
    bit rx_hold_req = 1'b0;

    // Escape letters and hex digits to draw from
    string named_letters = "abfnrstvE";
    string hex_chars     = "0123456789abcdefABCDEF";

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decode model
    // ------------------------------------------------------------------------
    function automatic bit is_octal(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    // -1 when the byte is not a hex digit
    function automatic int hex_value(logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE)
            return int'(b - CH_ZERO);
        if (b >= CH_LOWER_A && b <= CH_LOWER_F)
            return int'(b - CH_LOWER_A) + HEX_LETTER_BASE;
        if (b >= CH_UPPER_A && b <= CH_UPPER_F)
            return int'(b - CH_UPPER_A) + HEX_LETTER_BASE;
        return -1;
    endfunction

    function void add_char(logic [31:0] value, logic esc);
        out_word_t w;
        w.char_value  = value;
        w.from_escape = esc;
        w.last_of_run = 1'b0;
        run_chars.push_back(w);
    endfunction

    function void model_clear();
        model_mode      = DM_PLAIN;
        model_acc       = '0;
        model_octal_cnt = '0;
    endfunction

    // A byte seen outside any escape
    function void model_plain(logic [7:0] b);
        if (b == CH_BACKSLASH)
            model_mode = DM_AFTER_BSLASH;
        else
        begin
            model_mode = DM_PLAIN;
            add_char({24'd0, b}, 1'b0);
        end
    endfunction

    // The byte right after a backslash
    function void model_escaped(logic [7:0] b);
        logic [31:0] value;
        value      = {24'd0, b};
        model_mode = DM_PLAIN;
        if (is_octal(b))
        begin
            model_acc       = {24'd0, b - CH_ZERO};
            model_octal_cnt = 2'd1;
            model_mode      = DM_OCTAL;
            return;
        end
        case (b)
            "a":     value = VAL_BELL;
            "b":     value = VAL_BACKSPACE;
            "f":     value = VAL_FORMFEED;
            "n":     value = VAL_NEWLINE;
            "r":     value = VAL_RETURN;
            "s":     value = VAL_SPACE;
            "t":     value = VAL_TAB;
            "v":     value = VAL_VTAB;
            "E":     value = VAL_ESCAPE;
            CH_HEX_START:
            begin
                model_acc  = '0;
                model_mode = DM_HEX;
                return;
            end
            default: ; // any other byte stands for itself
        endcase
        add_char(value, 1'b1);
    endfunction

    // Works out every result caused by one accepted input word
    function void predict_decoded(in_word_t w);
        int digit;
        run_chars.delete();
        if (w.end_of_string)
        begin
            if (model_mode == DM_AFTER_BSLASH)
                add_char('0, 1'b1);
            else if (model_mode == DM_OCTAL || model_mode == DM_HEX)
                add_char(model_acc, 1'b1);
            model_clear();
        end
        else
        begin
            case (model_mode)
                DM_PLAIN:        model_plain(w.byte_in);
                DM_AFTER_BSLASH: model_escaped(w.byte_in);
                DM_OCTAL:
                begin
                    if (is_octal(w.byte_in))
                    begin
                        model_acc       = (model_acc << 3) + {24'd0, w.byte_in - CH_ZERO};
                        model_octal_cnt = model_octal_cnt + 2'd1;
                        if (model_octal_cnt == 2'd3)
                        begin
                            add_char(model_acc, 1'b1);
                            model_clear();
                        end
                    end
                    else
                    begin
                        // early end: value first, then the byte as plain text
                        add_char(model_acc, 1'b1);
                        model_acc       = '0;
                        model_octal_cnt = '0;
                        model_plain(w.byte_in);
                    end
                end
                default:
                begin
                    digit = hex_value(w.byte_in);
                    if (digit >= 0)
                        model_acc = (model_acc << 4) + 32'(digit);
                    else
                    begin
                        add_char(model_acc, 1'b1);
                        model_acc = '0;
                        model_plain(w.byte_in);
                    end
                end
            endcase
        end
        if (run_chars.size() > 0)
            run_chars[run_chars.size() - 1].last_of_run = 1'b1;
        if (run_chars.size() == 2)
            two_result_runs++;
        foreach (run_chars[i])
            expected_chars.push_back(run_chars[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Every call starts and ends on a rising edge; valid stays
    // high across back-to-back words and drops only when a gap is drawn or the sender pauses to drain.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic eos);
        int       gap;
        in_word_t w;
        gap             = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        w.byte_in       = b;
        w.end_of_string = eos;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_decoded(w);
        words_sent++;
        if (eos)
            end_words++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // byte field carries noise; the decoder must ignore it
    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Sender pause: nothing offered until every owed character has come back
    task automatic wait_results_drained();
        item_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker. A hold request from a test turns the next stall
    // into a long one, so the result queue fills and input backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        out_word_t want;
        int        hold;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                hold        = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            else
                hold = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);

            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR %0t: unexpected result value=%h esc=%0b last=%0b",
                             $realtime, result.char_value, result.from_escape,
                             result.last_of_run);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (result.char_value  !== want.char_value  ||
                    result.from_escape !== want.from_escape ||
                    result.last_of_run !== want.last_of_run)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"ERROR %0t: result #%0d expected value=%h esc=%0b last=%0b,",
                                  " got value=%h esc=%0b last=%0b"},
                                 $realtime, chars_checked, want.char_value,
                                 want.from_escape, want.last_of_run, result.char_value,
                                 result.from_escape, result.last_of_run);
                end
                chars_checked++;
                if (want.from_escape)
                    escape_chars++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hung handshake, or characters the DUT never returns, end
    // the run here.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ERROR %0t: no handshake for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, expected_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Plain bytes at both ends of the range, then end of string with
    // nothing pending, which must give no result at all.
    task automatic test_plain_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("A");
        send_end();
    endtask

    // All named escapes, an escaped backslash and an escaped zero byte
    task automatic test_named_escapes();
        send_text("\\a\\b\\f\\n\\r\\s\\t\\v\\E\\\\");
        send_word(CH_BACKSLASH, 1'b0);
        send_word(8'h00, 1'b0);
    endtask

    // Full three-digit octal, the largest value 511, an early end on a plain
    // byte (two results), and a backslash ending the octal and opening \n.
    task automatic test_octal_escapes();
        send_text("\\101\\777\\12z\\7\\n");
    endtask

    // Hex with no digits, nine digits that wrap past 32 bits ended by a
    // backslash that opens \t, and a mixed-case hex flushed by end of string.
    task automatic test_hex_escapes();
        send_text("\\xg\\x123456789\\t\\xAbC");
        send_end();
    endtask

    // Lone backslash at end of string gives zero, a pending octal flushes
    task automatic test_end_flush();
        send_text("\\");
        send_end();
        send_text("\\5");
        send_end();
        send_end();
    endtask

    // Long receiver stall while words keep coming back to back; each
    // triple ends an octal on a plain byte, so the queue fills quickly.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle = tx_idle;
        wait_results_drained();
        rx_hold_req = 1'b1;
        tx_idle     = 1'b0;
        for (int i = 0; i < FLOOD_REPEATS; i++)
            send_text("\\3q");
        tx_idle = saved_idle;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random stream
    // ------------------------------------------------------------------------

    // What follows a pending escape: nothing, any byte, end of string, or
    // a backslash that closes it and opens the next one
    task automatic send_random_ending();
        case ($urandom_range(0, 3))
            0:       ;
            1:       send_word(8'($urandom_range(0, 255)), 1'b0);
            2:       send_end();
            default: send_word(CH_BACKSLASH, 1'b0);
        endcase
    endtask

    task automatic send_random_sequence();
        int digits;
        case ($urandom_range(0, 15))
            0, 1:    send_word(8'($urandom_range(0, 255)), 1'b0);
            2, 3:    send_word(8'($urandom_range(32, 126)), 1'b0);
            4, 5:
            begin
                send_word(CH_BACKSLASH, 1'b0);
                send_word(named_letters[$urandom_range(0, named_letters.len() - 1)], 1'b0);
            end
            6:
            begin
                send_word(CH_BACKSLASH, 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            7, 8, 9:
            begin
                send_word(CH_BACKSLASH, 1'b0);
                digits = $urandom_range(1, 3);
                for (int i = 0; i < digits; i++)
                    send_word(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
                if (digits < 3)
                    send_random_ending();
            end
            10, 11, 12:
            begin
                send_text("\\x");
                // mostly short runs, now and then long enough to fill or wrap the value
                digits = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12)
                                                     : $urandom_range(0, 4);
                for (int i = 0; i < digits; i++)
                    send_word(hex_chars[$urandom_range(0, hex_chars.len() - 1)], 1'b0);
                send_random_ending();
            end
            13:      send_end();
            14:
            begin
                send_word(CH_BACKSLASH, 1'b0);
                send_end();
            end
            default: send_word(CH_BACKSLASH, 1'b0);
        endcase
    endtask

    task automatic test_random_stream(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target)
        begin
            // switch idling on and off now and then, for bursts and gaps
            if ($urandom_range(0, 40) == 0)
                tx_idle = ~tx_idle;
            if ($urandom_range(0, 40) == 0)
                rx_idle = ~rx_idle;
            send_random_sequence();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        model_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_named_escapes();
        test_octal_escapes();
        test_hex_escapes();
        test_end_flush();
        test_backpressure();
        test_random_stream(RANDOM_WORDS);

        wait_results_drained();

        $display("Sent %0d words (%0d end-of-string), checked %0d results",
                 words_sent, end_words, chars_checked);
        $display("  %0d results from escapes, %0d words that gave two results",
                 escape_chars, two_result_runs);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
